// ----- rtl/quadratic_gray_color_balance_assert.svh -----
// Assertion macros for the color balance block
`ifndef QUADRATIC_GRAY_COLOR_BALANCE_ASSERT_SVH
`define QUADRATIC_GRAY_COLOR_BALANCE_ASSERT_SVH

// checked only out of reset
`define QGCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qgcb assertion failed");

// checked on every edge, reset included
`define QGCB_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("qgcb reset check failed");

`endif

// ----- rtl/qgcb_pkg.sv -----
// Package: constants, codes and queue entry type of the color balance block
`timescale 1ns / 1ps
package qgcb_pkg;
  localparam int MAX_FRAME_PIXELS = 4194304;
  localparam int GAIN_FRAC_BITS   = 16;
  localparam int PIX_W   = 8;
  localparam int GRAY_W  = 17;
  localparam int SUM_W   = 30;
  localparam int COUNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int GAIN_W  = GAIN_FRAC_BITS + 11;
  localparam int CNUM_W  = GAIN_W + 16;
  localparam int DIV_DW  = 36 + GAIN_FRAC_BITS;
  localparam int DIV_VW  = 34;
  localparam int DIV_CW  = $clog2(DIV_DW);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_LIMIT = GAIN_W'(512) << GAIN_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO   = 3'd0,
    CFG_TARGET = 3'd1,
    CFG_REF_R  = 3'd2,
    CFG_REF_G  = 3'd3,
    CFG_REF_B  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_CAL,
    OP_CAL_END,
    OP_CORR
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [2:0][PIX_W-1:0] px;
  } qent_t;
endpackage

// ----- rtl/qgcb_div.sv -----
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module qgcb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qgcb_pkg::DIV_DW-1:0] dividend,
  input  logic [qgcb_pkg::DIV_VW-1:0] divisor,
  output logic                       done,
  output logic [qgcb_pkg::DIV_DW-1:0] quotient
);
  import qgcb_pkg::*;

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_VW:0]   rem_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW+1:0] trial;

  assign shifted  = {rem_r[DIV_VW-1:0], quo_r[DIV_DW-1]};
  assign trial    = {1'b0, shifted} - {2'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CW'(DIV_DW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!trial[DIV_VW+1]) begin
          rem_r <= trial[DIV_VW:0];
          quo_r <= {quo_r[DIV_DW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[DIV_DW-2:0], 1'b0};
        end
        if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/qgcb_front.sv -----
// Front: decodes pixel beats and queues them for the back end
`timescale 1ns / 1ps
module qgcb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [qgcb_pkg::PIX_W-1:0]    in_red,
  input  logic [qgcb_pkg::PIX_W-1:0]    in_green,
  input  logic [qgcb_pkg::PIX_W-1:0]    in_blue,
  input  logic                          in_frame_end,
  output logic                          q_valid,
  output qgcb_pkg::qent_t               q_ent,
  input  logic                          q_pop
);
  import qgcb_pkg::*;

  qent_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  qent_t      dec;
  logic       push;

  always_comb begin
    dec.px = {in_blue, in_green, in_red};
    if (in_kind)
      dec.op = OP_CORR;
    else if (in_frame_end)
      dec.op = OP_CAL_END;
    else
      dec.op = OP_CAL;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_ent    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        ent_r[wp_r] <= dec;
        wp_r        <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ----- rtl/qgcb_back.sv -----
// Back: calibration sums, gray means, gains and curve per channel
`timescale 1ns / 1ps
module qgcb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [qgcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qgcb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              q_valid,
  input  qgcb_pkg::qent_t                   q_ent,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [qgcb_pkg::PIX_W-1:0]        out_red,
  output logic [qgcb_pkg::PIX_W-1:0]        out_green,
  output logic [qgcb_pkg::PIX_W-1:0]        out_blue
);
  import qgcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_MWAIT, S_PREP, S_GAIN, S_GWAIT,
    S_CMUL, S_CSUM, S_CWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] ch_r;

  logic              auto_r;
  logic [GRAY_W-1:0] tgt_r;
  logic [GRAY_W-1:0] ref_r [3];

  logic [SUM_W-1:0]   sum_r [3];
  logic [COUNT_W-1:0] count_r;
  logic [GRAY_W-1:0]  mg_r [3];
  logic               mvalid_r;

  logic [2:0][PIX_W-1:0] pix_r;
  logic [PIX_W-1:0]      res_r [3];
  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_red_r, out_green_r, out_blue_r;

  logic [33:0]              sq_r;
  logic signed [35:0]       den_r;
  logic [14:0]              pp_r;
  logic [15:0]              pq_r;
  logic                     eqt_r, neg_r;
  logic signed [GAIN_W-1:0] c_r;
  logic signed [CNUM_W-1:0] prod_r;
  logic signed [CNUM_W-1:0] cnum_r;

  logic              div_start_r, div_done;
  logic [DIV_DW-1:0] div_a_r, div_q;
  logic [DIV_VW-1:0] div_b_r;

  logic [GRAY_W-1:0]        g_c;
  logic [PIX_W-1:0]         p_c;
  logic [33:0]              sq_c;
  logic signed [35:0]       den_c;
  logic [15:0]              pp_c, pq_c;
  logic [30:0]              mden_c;
  logic signed [35:0]       num0_c;
  logic signed [DIV_DW-1:0] num_c;
  logic [DIV_DW-1:0]        an_c;
  logic [35:0]              ad_c;
  logic [GAIN_W-1:0]        cq_c;
  logic signed [CNUM_W-1:0] cnum_c;
  logic [CNUM_W-GAIN_FRAC_BITS-1:0] cx_c;
  logic [16:0]              cdiv_c;
  logic                     take;

  qgcb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .dividend(div_a_r),
    .divisor (div_b_r),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    g_c    = (auto_r && mvalid_r) ? mg_r[ch_r] : ref_r[ch_r];
    p_c    = pix_r[ch_r];
    sq_c   = g_c * g_c;
    den_c  = $signed({19'b0, g_c}) * (36'sd65536 - $signed({19'b0, g_c}));
    pp_c   = {8'b0, p_c} * (16'd255 - {8'b0, p_c});
    pq_c   = {8'b0, p_c} * {8'b0, p_c};
    mden_c = {count_r, 8'b0} - {8'b0, count_r};
    num0_c = $signed({3'b0, tgt_r, 16'b0}) - $signed({2'b0, sq_r});
    num_c  = DIV_DW'(num0_c) <<< GAIN_FRAC_BITS;
    an_c   = num_c[DIV_DW-1] ? DIV_DW'(-num_c) : DIV_DW'(num_c);
    ad_c   = den_r[35] ? 36'(-den_r) : 36'(den_r);
    cq_c   = (div_q > DIV_DW'(GAIN_LIMIT)) ? GAIN_LIMIT : div_q[GAIN_W-1:0];
    cnum_c = $signed(CNUM_W'(pq_r) << GAIN_FRAC_BITS) + prod_r;
    // divide by 255 after dropping the fraction bits
    cx_c   = cnum_r[CNUM_W-1:GAIN_FRAC_BITS];
    cdiv_c = {1'b0, cx_c[15:0]} + {9'b0, cx_c[15:8]} + 17'd1;
  end

  assign take      = out_valid_r && out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      auto_r      <= 1'b0;
      tgt_r       <= GRAY_W'(32768);
      ref_r       <= '{default: GRAY_W'(32768)};
      sum_r       <= '{default: '0};
      count_r     <= '0;
      mg_r        <= '{default: '0};
      mvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= ((state_r == S_MEAN) && (mden_c != '0)) ||
                     ((state_r == S_GAIN) && !(eqt_r || den_r == '0));
      if (take && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_AUTO:   auto_r   <= cfg_data[0];
          CFG_TARGET: tgt_r    <= cfg_data;
          CFG_REF_R:  ref_r[0] <= cfg_data;
          CFG_REF_G:  ref_r[1] <= cfg_data;
          CFG_REF_B:  ref_r[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            pix_r <= q_ent.px;
            ch_r  <= '0;
            if (q_ent.op inside {OP_CAL, OP_CAL_END}) begin
              if (count_r < COUNT_W'(MAX_FRAME_PIXELS)) begin
                for (int i = 0; i < 3; i++)
                  sum_r[i] <= sum_r[i] + SUM_W'(q_ent.px[i]);
                count_r <= count_r + 1'b1;
              end
              if (q_ent.op == OP_CAL_END) state_r <= S_MEAN;
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_MEAN: begin
          if (mden_c == '0) begin
            mg_r[ch_r] <= '0;
            if (ch_r == 2'd2) begin
              sum_r    <= '{default: '0};
              count_r  <= '0;
              mvalid_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              ch_r <= ch_r + 1'b1;
            end
          end else begin
            div_a_r <= DIV_DW'({sum_r[ch_r], 16'b0}) + DIV_DW'(mden_c >> 1);
            div_b_r <= DIV_VW'(mden_c);
            state_r <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (div_done) begin
            mg_r[ch_r] <= div_q[GRAY_W-1:0];
            if (ch_r == 2'd2) begin
              sum_r    <= '{default: '0};
              count_r  <= '0;
              mvalid_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_MEAN;
            end
          end
        end
        S_PREP: begin
          sq_r    <= sq_c;
          den_r   <= den_c;
          pp_r    <= pp_c[14:0];
          pq_r    <= pq_c;
          eqt_r   <= (tgt_r == g_c);
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          if (eqt_r || den_r == '0) begin
            c_r     <= $signed(GAIN_ONE);
            state_r <= S_CMUL;
          end else begin
            neg_r   <= num0_c[35] ^ den_r[35];
            div_a_r <= an_c + DIV_DW'(ad_c[33:0] >> 1);
            div_b_r <= ad_c[33:0];
            state_r <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (div_done) begin
            c_r     <= neg_r ? -$signed(cq_c) : $signed(cq_c);
            state_r <= S_CMUL;
          end
        end
        S_CMUL: begin
          prod_r  <= CNUM_W'(c_r * $signed({1'b0, pp_r}));
          state_r <= S_CSUM;
        end
        S_CSUM: begin
          cnum_r  <= cnum_c;
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cnum_r <= 0)
            res_r[ch_r] <= '0;
          else if (cx_c >= (CNUM_W-GAIN_FRAC_BITS)'(65280))
            res_r[ch_r] <= 8'd255;
          else
            res_r[ch_r] <= cdiv_c[15:8];
          if (ch_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_PREP;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_red_r   <= res_r[0];
            out_green_r <= res_r[1];
            out_blue_r  <= res_r[2];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/quadratic_gray_color_balance.sv -----
// Top level: gray-world color balance with a quadratic correction curve
//
//  channel | direction | beat contents
//  in_     | sink      | kind, red, green, blue, frame_end
//  out_    | source    | out_red, out_green, out_blue
//  cfg_    | sink      | cfg_index, cfg_data (always ready)
//
// Correction pixel: per channel the gain division, 52 steps of the shared bit-serial
// divider, takes most of the time; a unity gain skips the divider.
// Calibration pixel: accumulated from idle; frame end runs the divider for the means.
// A two-beat queue sits between intake and the sequencer; a full output
// register holds the sequencer, not the queue. Sync reset sets control and config.
`timescale 1ns / 1ps
module quadratic_gray_color_balance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [qgcb_pkg::PIX_W-1:0]      in_red,
  input  logic [qgcb_pkg::PIX_W-1:0]      in_green,
  input  logic [qgcb_pkg::PIX_W-1:0]      in_blue,
  input  logic                            in_frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qgcb_pkg::PIX_W-1:0]      out_red,
  output logic [qgcb_pkg::PIX_W-1:0]      out_green,
  output logic [qgcb_pkg::PIX_W-1:0]      out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qgcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qgcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qgcb_pkg::*;

  logic  q_valid, q_pop;
  qent_t q_ent;

  assign cfg_ready = 1'b1;

  qgcb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_frame_end(in_frame_end),
    .q_valid     (q_valid),
    .q_ent       (q_ent),
    .q_pop       (q_pop)
  );

  qgcb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_ent    (q_ent),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );
endmodule

// ----- rtl/qgcb_checker.sv -----
// Port checker for the color balance block, bound to the top level
`timescale 1ns / 1ps
`include "quadratic_gray_color_balance_assert.svh"
module qgcb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_kind,
  input logic [qgcb_pkg::PIX_W-1:0]      in_red,
  input logic [qgcb_pkg::PIX_W-1:0]      in_green,
  input logic [qgcb_pkg::PIX_W-1:0]      in_blue,
  input logic                            in_frame_end,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [qgcb_pkg::PIX_W-1:0]      out_red,
  input logic [qgcb_pkg::PIX_W-1:0]      out_green,
  input logic [qgcb_pkg::PIX_W-1:0]      out_blue,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [qgcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [qgcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  `QGCB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `QGCB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_red, out_green, out_blue}))
  `QGCB_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)
  `QGCB_ASSERT_ANY(a_rst_out, !rst_n |=> !out_valid)
endmodule

bind quadratic_gray_color_balance qgcb_checker u_qgcb_checker (.*);
